[rtl/core/swp2p_pkg.sv]
// ----------------------------------------------------------------------------
// swp2p_pkg: shared types and defaults for the sliding window peak-to-peak core
// Holds the default window geometry and the control bundle that the sequencer
// hands to the compare unit.
// ----------------------------------------------------------------------------
package swp2p_pkg;

	localparam int DEFAULT_WINDOW      = 100;
	localparam int DEFAULT_SAMPLE_BITS = 10;

	// control from the sequencer to the shared compare unit
	typedef struct packed {
		logic clear;   // restart the running max/min
		logic en;      // fold the current read data in
	} swp2p_cmp_ctrl_t;

endpackage

[rtl/core/swp2p_store.sv]
// ----------------------------------------------------------------------------
// swp2p_store: window sample memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swp2p_store #(
	parameter int DEPTH  = 100,
	parameter int DATA_W = 10,
	parameter int ADDR_W = 7
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/core/swp2p_minmax.sv]
// ----------------------------------------------------------------------------
// swp2p_minmax: shared compare unit
// Folds one sample per cycle, while en is set, into a running maximum and minimum.
// ----------------------------------------------------------------------------
module swp2p_minmax
	import swp2p_pkg::*;
#(
	parameter int DATA_W = 10
) (
	input  logic            clk,
	input  swp2p_cmp_ctrl_t ctrl,
	input  logic [DATA_W-1:0] value,
	output logic [DATA_W-1:0] hi,
	output logic [DATA_W-1:0] lo
);

	logic [DATA_W-1:0] hi_q;
	logic [DATA_W-1:0] lo_q;

	// clear seeds the max with all zeros and the min with all ones
	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			hi_q <= '0;
			lo_q <= '1;
		end else if (ctrl.en) begin
			if (value > hi_q) begin
				hi_q <= value;
			end
			if (value < lo_q) begin
				lo_q <= value;
			end
		end
	end

	assign hi = hi_q;
	assign lo = lo_q;

endmodule

[rtl/core/sliding_window_peak_to_peak_core.sv]
// ----------------------------------------------------------------------------
// sliding_window_peak_to_peak_core: windowed max, min and peak-to-peak level
// Keeps the most recent WINDOW samples in a ring and reports, per sample,
// the largest, the smallest and their difference over the filled entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input request (s_axis_*): one sample in tdata, taken when tvalid and
//   tready are both high. tready is high only while the core is idle.
//   Output request (m_axis_*): one result per sample, packed max, min and
//   peak-to-peak in tdata, held in an output register until taken.
//   Sequence: after a sample is taken, one read per filled entry walks the
//   memory through a single compare unit: ST_SCAN issues the reads,
//   ST_DRAIN folds in the last read data and ST_DONE loads the result. The
//   next sample is taken only after the result is loaded, once the core is
//   back in ST_IDLE. The single memory read port sets the pace of the scan.
//   Stall: a new sample is taken while an earlier result still waits; the
//   core then waits in ST_DONE, its new result held in the compare unit,
//   until the output register frees up, and stays not ready meanwhile.
//   Reset: arst_n clears fill count, write pointer and all control state at
//   once. The sample memory is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module sliding_window_peak_to_peak_core
	import swp2p_pkg::*;
#(
	parameter int WINDOW      = DEFAULT_WINDOW,
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
	localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	// input: [SAMPLE_BITS-1:0] sample, zeros above
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,
	// output: window_max, then window_min, then peak_to_peak, zeros above
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int PTR_W  = $clog2(WINDOW);
	localparam int FILL_W = PTR_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t               state_q;
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [FILL_W-1:0]    fill_q;
	logic [PTR_W-1:0]     idx_q;
	logic                 rd_vld_s1;
	logic                 m_valid_q;
	logic [3*SAMPLE_BITS-1:0] m_data_q;

	logic                 accept;
	logic                 scan_last;
	logic                 out_free;
	logic [SAMPLE_BITS-1:0] sample;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic [SAMPLE_BITS-1:0] hi;
	logic [SAMPLE_BITS-1:0] lo;
	logic [SAMPLE_BITS-1:0] p2p;
	swp2p_cmp_ctrl_t      cmp_ctrl;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];

	// last entry of the filled region; fill_q is at least one while scanning
	assign scan_last = ({1'b0, idx_q} == (fill_q - FILL_W'(1)));

	// output register can take a result when empty or being drained
	assign out_free = !m_valid_q || m_axis_tready;

	assign p2p = hi - lo;

	assign cmp_ctrl.clear = accept;
	assign cmp_ctrl.en    = rd_vld_s1;

	swp2p_store #(
		.DEPTH  (WINDOW),
		.DATA_W (SAMPLE_BITS),
		.ADDR_W (PTR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (wr_ptr_q),
		.wr_data (sample),
		.rd_en   (state_q == ST_SCAN),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	swp2p_minmax #(
		.DATA_W (SAMPLE_BITS)
	) u_minmax (
		.clk   (clk),
		.ctrl  (cmp_ctrl),
		.value (rd_data),
		.hi    (hi),
		.lo    (lo)
	);

	// sequencer: state, ring bookkeeping and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wr_ptr_q  <= '0;
			fill_q    <= '0;
			idx_q     <= '0;
			rd_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			rd_vld_s1 <= (state_q == ST_SCAN);

			// drop a result the receiver has taken; a result loading in
			// ST_DONE takes its place instead
			if (m_valid_q && m_axis_tready && state_q != ST_DONE) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						// advance the ring pointer, wrap at the window end
						if (wr_ptr_q == PTR_W'(WINDOW - 1)) begin
							wr_ptr_q <= '0;
						end else begin
							wr_ptr_q <= wr_ptr_q + PTR_W'(1);
						end
						// grow the fill count until the window is full
						if (fill_q != FILL_W'(WINDOW)) begin
							fill_q <= fill_q + FILL_W'(1);
						end
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + PTR_W'(1);
					end
				end
				ST_DRAIN: begin
					// last read data folds in at this edge
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= {p2p, lo, hi};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_W'(m_data_q);

	// fill count never passes the window depth
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW))
		else $error("fill count beyond window depth");

	// a taken sample always starts a scan on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SCAN))
		else $error("accepted sample did not start a scan");

	// the scan index stays inside the filled region
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({1'b0, idx_q} < fill_q))
		else $error("scan index outside filled entries");

	// read data is only expected right after a scan cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("read data valid outside scan");

	// a presented result always has max not below min
	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_data_q[SAMPLE_BITS-1:0] >= m_data_q[2*SAMPLE_BITS-1:SAMPLE_BITS]))
		else $error("window max below window min");

endmodule

[dv/peak_to_peak_checker.sv]
// ----------------------------------------------------------------------------
// peak_to_peak_checker: scoreboard for the sliding window peak-to-peak core
// Mirrors the sample window, works out the max, min and level that every
// accepted sample must produce, and compares them with each result request.
// ----------------------------------------------------------------------------
module peak_to_peak_checker
	import swp2p_pkg::*;
#(
	parameter int WINDOW      = DEFAULT_WINDOW,
	parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
	localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // sample, zeros above
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [OUT_W-1:0] m_tdata,   // window_max, window_min, peak_to_peak, zeros above
	output int               failures,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	// first field sits in the lowest bits, so it is declared last
	typedef struct packed {
		logic [OUT_W-3*SAMPLE_BITS-1:0] pad;
		sample_t                        peak_to_peak;
		sample_t                        window_min;
		sample_t                        window_max;
	} level_t;

	sample_t     window_ring [WINDOW];
	int unsigned filled   = 0;
	int unsigned wr_slot  = 0;
	level_t      expected_levels [$];
	level_t      got, want;
	int          fail_count = 0;

	// store the new sample, then scan every filled slot
	task automatic store_and_scan(input sample_t smp, output level_t lvl);
		sample_t hi;
		sample_t lo;
		hi = '0;
		lo = '1;
		window_ring[wr_slot] = smp;
		wr_slot = (wr_slot + 1 == WINDOW) ? 0 : wr_slot + 1;
		if (filled < WINDOW)
			filled++;
		for (int i = 0; i < filled; i++) begin
			if (window_ring[i] > hi)
				hi = window_ring[i];
			if (window_ring[i] < lo)
				lo = window_ring[i];
		end
		lvl              = '0;
		lvl.window_max   = hi;
		lvl.window_min   = lo;
		lvl.peak_to_peak = hi - lo;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_levels.delete();
			filled  = 0;
			wr_slot = 0;
		end else begin
			// results leave before the sample of this edge can add one
			if (m_tvalid && m_tready) begin
				got = level_t'(m_tdata);
				if (expected_levels.size() == 0) begin
					$error("result with nothing expected: tdata %h", m_tdata);
					fail_count++;
				end else begin
					want = expected_levels.pop_front();
					if (got.window_max !== want.window_max) begin
						$error("window_max: expected %0d, got %0d", want.window_max,
							got.window_max);
						fail_count++;
					end
					if (got.window_min !== want.window_min) begin
						$error("window_min: expected %0d, got %0d", want.window_min,
							got.window_min);
						fail_count++;
					end
					if (got.peak_to_peak !== want.peak_to_peak) begin
						$error("peak_to_peak: expected %0d, got %0d", want.peak_to_peak,
							got.peak_to_peak);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				store_and_scan(s_tdata[SAMPLE_BITS-1:0], want);
				expected_levels.push_back(want);
			end
		end
		failures    <= fail_count;
		outstanding <= expected_levels.size();
	end

endmodule

[dv/tb_sliding_window_peak_to_peak_core.sv]
// ----------------------------------------------------------------------------
// tb_sliding_window_peak_to_peak_core: testbench top for the peak-to-peak core
// Feeds directed and patterned random samples through the input request
// channel with random gaps and output stalls; a checker beside the core
// predicts every result and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_sliding_window_peak_to_peak_core;
	timeunit 1ns;
	timeprecision 1ps;

	import swp2p_pkg::*;

	localparam int WINDOW       = DEFAULT_WINDOW;
	localparam int SAMPLE_BITS  = DEFAULT_SAMPLE_BITS;
	localparam int IN_W         = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int OUT_W        = ((3 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
	localparam int RANDOM_ITEMS = 1600;
	// slowest run: a full scan, the longest idle gap and the longest stall per sample, with a fourfold margin
	localparam longint CYCLE_LIMIT = 5_000_000;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	// shapes of the random sample runs
	typedef enum int {
		PAT_UNIFORM,
		PAT_NOISE,
		PAT_RAMP,
		PAT_SPIKE,
		PAT_BITWALK
	} pattern_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata  = '0;   // sample, zeros above
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;         // window_max, window_min, peak_to_peak, zeros above

	int     failures;
	int     outstanding;
	longint cycle_count = 0;
	bit     no_idle     = 1'b0;        // both sides run flat out while set
	bit     out_enable  = 1'b0;
	int     stall_left  = 0;

	always #6 clk = ~clk;

	sliding_window_peak_to_peak_core #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	peak_to_peak_checker #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) level_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// Mostly short gaps, now and then a long one that can outlast a full scan.
	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(20, 250);
		return $urandom_range(0, 3);
	endfunction

	// Offer one sample after an idle gap and hold it until the core takes it.
	// With no gap, tvalid simply stays high into the next request.
	task automatic push_sample(input sample_t smp, input int unsigned gap);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W-SAMPLE_BITS){1'b0}}, smp};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Output side: stall at random, never while a flat-out stretch runs.
	always @(posedge clk) begin
		if (!out_enable) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0 && !no_idle) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready   <= 1'b1;
			stall_left = 0;
			if (!no_idle && $urandom_range(0, 99) < 8)
				stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
					: $urandom_range(1, 4);
		end
	end

	// Watchdog: drop the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		sample_t     directed_samples [14];
		sample_t     smp;
		pattern_t    pat;
		int          sent;
		int          run_len;
		int          base;
		int          step;
		int          v;
		bit          invert;
		bit          falling;

		// Directed: a lone first sample, both rail values so the level hits
		// its full scale, alternating bit patterns, neighbors of the rails and
		// of mid scale, and a repeated value.
		directed_samples = '{
			10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1, 10'd1022, 10'd512,
			10'd511, 10'd700, 10'd700, 10'd3, 10'd1000, 10'h3FE, 10'h001
		};

		// hold reset, then release it on a rising edge
		repeat (5) @(posedge clk);
		arst_n     <= 1'b1;
		@(posedge clk);
		out_enable <= 1'b1;

		foreach (directed_samples[i])
			push_sample(directed_samples[i], pick_gap());

		// Random runs: each run has a shape so the window sees plateaus,
		// ramps, lone spikes that later slide out, and single set or cleared bits.
		// Filling the window and wrapping the ring happens early here and
		// then many times over.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pat     = pattern_t'($urandom_range(0, 4));
			run_len = $urandom_range(20, 150);
			no_idle = ($urandom_range(0, 4) == 0);
			base    = $urandom_range(0, SAMPLE_MAX);
			step    = $urandom_range(1, 12);
			falling = 1'($urandom_range(0, 1));
			invert  = 1'($urandom_range(0, 1));
			for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
				case (pat)
					PAT_UNIFORM: begin
						smp = sample_t'($urandom_range(0, SAMPLE_MAX));
					end
					PAT_NOISE: begin
						v = base + int'($urandom_range(0, 16)) - 8;
						if (v < 0)
							v = 0;
						else if (v > SAMPLE_MAX)
							v = SAMPLE_MAX;
						smp = sample_t'(v);
					end
					PAT_RAMP: begin
						v   = falling ? base - k * step : base + k * step;
						smp = sample_t'(v);   // wrap at the rails
					end
					PAT_SPIKE: begin
						if ($urandom_range(0, 29) == 0)
							smp = $urandom_range(0, 1) ? sample_t'(SAMPLE_MAX) : '0;
						else
							smp = sample_t'(base);
					end
					default: begin
						smp = sample_t'(1) << $urandom_range(0, SAMPLE_BITS - 1);
						if (invert)
							smp = ~smp;
					end
				endcase
				push_sample(smp, no_idle ? 0 : pick_gap());
				sent++;
			end
		end
		no_idle  = 1'b0;
		s_tvalid <= 1'b0;

		// let the checker count the last request, drain, then allow one
		// full scan more for stray results
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (WINDOW + 8) @(posedge clk);

		if (failures == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
